/* sv/ukt_pkg.sv */
package ukt_pkg;

  // table geometry
  localparam int unsigned DEPTH      = 64;
  localparam int unsigned NAME_BYTES = 8;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // field widths
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned NAME_W    = 8 * NAME_BYTES;
  localparam int unsigned NAME_IN_W = 64;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned STATUS_W  = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GET = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UPD = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd4;

  // source of a table write
  typedef enum logic [1:0] {
    WSEL_KEY,
    WSEL_NEW_KEY,
    WSEL_SHIFT
  } wr_sel_e;

  typedef struct packed {
    logic                load_req;
    logic                rd_en;
    logic                scan;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    wr_sel_e             wr_sel;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                res_found;
  } cmd_t;

  typedef struct packed {
    logic             hit_k;
    logic             hit_nk;
    logic [IDX_W-1:0] at_idx;
    logic [IDX_W-1:0] other_idx;
  } sts_t;

endpackage

/* sv/ukt_dp.sv */
module ukt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ukt_pkg::KEY_W-1:0]     in_key_i,
  input  logic [ukt_pkg::KEY_W-1:0]     in_new_key_i,
  input  logic [ukt_pkg::NAME_IN_W-1:0] in_name_i,
  input  ukt_pkg::cmd_t                 cmd_i,
  output ukt_pkg::sts_t                 sts_o,
  output logic [ukt_pkg::STATUS_W-1:0]  out_status_o,
  output logic [ukt_pkg::KEY_W-1:0]     out_key_o,
  output logic [ukt_pkg::NAME_IN_W-1:0] out_name_o
);

  logic [ukt_pkg::KEY_W-1:0]  key_mem  [ukt_pkg::DEPTH];
  logic [ukt_pkg::NAME_W-1:0] name_mem [ukt_pkg::DEPTH];

  logic [ukt_pkg::KEY_W-1:0]  req_key_q, req_new_key_q;
  logic [ukt_pkg::NAME_W-1:0] req_name_q;
  logic [ukt_pkg::KEY_W-1:0]  rd_key_q;
  logic [ukt_pkg::NAME_W-1:0] rd_name_q;
  logic                       cmp_vld_q;
  logic [ukt_pkg::IDX_W-1:0]  cmp_idx_q;
  logic                       hit_k_q, hit_nk_q;
  logic [ukt_pkg::IDX_W-1:0]  at_q, other_q;
  logic [ukt_pkg::NAME_W-1:0] match_name_q;
  logic [ukt_pkg::STATUS_W-1:0]  res_status_q;
  logic [ukt_pkg::KEY_W-1:0]     res_key_q;
  logic [ukt_pkg::NAME_IN_W-1:0] res_name_q;

  logic [ukt_pkg::KEY_W-1:0]  wr_key;
  logic [ukt_pkg::NAME_W-1:0] wr_name;

  always_comb begin
    case (cmd_i.wr_sel)
      ukt_pkg::WSEL_KEY: begin
        wr_key  = req_key_q;
        wr_name = req_name_q;
      end
      ukt_pkg::WSEL_NEW_KEY: begin
        wr_key  = req_new_key_q;
        wr_name = req_name_q;
      end
      default: begin
        wr_key  = rd_key_q;
        wr_name = rd_name_q;
      end
    endcase
  end

  // table storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      key_mem[cmd_i.wr_addr]  <= wr_key;
      name_mem[cmd_i.wr_addr] <= wr_name;
    end
    if (cmd_i.rd_en) begin
      rd_key_q  <= key_mem[cmd_i.rd_addr];
      rd_name_q <= name_mem[cmd_i.rd_addr];
    end
  end

  // request operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_key_q     <= in_key_i;
      req_new_key_q <= in_new_key_i;
      req_name_q    <= in_name_i[ukt_pkg::NAME_W-1:0];
    end
  end

  // compare stage behind the read port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
      hit_k_q   <= 1'b0;
      hit_nk_q  <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.rd_en && cmd_i.scan;
      if (cmd_i.load_req) begin
        hit_k_q  <= 1'b0;
        hit_nk_q <= 1'b0;
      end else if (cmp_vld_q) begin
        if (rd_key_q == req_key_q) hit_k_q <= 1'b1;
        if (rd_key_q == req_new_key_q) hit_nk_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmd_i.rd_addr;
    if (cmp_vld_q && (rd_key_q == req_key_q)) begin
      at_q         <= cmp_idx_q;
      match_name_q <= rd_name_q;
    end
    if (cmp_vld_q && (rd_key_q == req_new_key_q)) begin
      other_q <= cmp_idx_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      if (cmd_i.res_found) begin
        res_key_q  <= req_key_q;
        res_name_q <= ukt_pkg::NAME_IN_W'(match_name_q);
      end else begin
        res_key_q  <= '0;
        res_name_q <= '0;
      end
    end
  end

  assign sts_o.hit_k     = hit_k_q;
  assign sts_o.hit_nk    = hit_nk_q;
  assign sts_o.at_idx    = at_q;
  assign sts_o.other_idx = other_q;

  assign out_status_o = res_status_q;
  assign out_key_o    = res_key_q;
  assign out_name_o   = res_name_q;

endmodule

/* sv/ukt_ctrl.sv */
module ukt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ukt_pkg::KIND_W-1:0]   in_kind_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  input  logic                         cfg_we_i,
  input  logic [ukt_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  ukt_pkg::sts_t                sts_i,
  output ukt_pkg::cmd_t                cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_SHIFT  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [ukt_pkg::KIND_W-1:0]  kind_q, kind_d;
  logic [ukt_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [ukt_pkg::CAP_W-1:0]   cap_q, cap_d;
  logic [ukt_pkg::CNT_W-1:0]   idx_q, idx_d;
  logic                        wr_pend_q, wr_pend_d;
  logic [ukt_pkg::IDX_W-1:0]   wr_dst_q, wr_dst_d;
  logic                        out_vld_q, out_vld_d;

  logic                        in_acc, out_free, full;
  logic [ukt_pkg::CNT_W-1:0]   idx_nxt;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign idx_nxt     = idx_q + ukt_pkg::CNT_W'(1);
  assign full        = (32'(cnt_q) >= 32'(cap_q)) || (cnt_q == ukt_pkg::CNT_W'(ukt_pkg::DEPTH));

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    wr_pend_d = wr_pend_q;
    wr_dst_d  = wr_dst_q;
    cap_d     = cfg_we_i ? cfg_wdata_i : cap_q;

    cmd_o            = '0;
    cmd_o.wr_sel     = ukt_pkg::WSEL_KEY;
    cmd_o.res_status = ukt_pkg::ST_OK;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.load_req = 1'b1;
          kind_d         = in_kind_i;
          idx_d          = '0;
          state_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q < cnt_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.scan    = 1'b1;
          cmd_o.rd_addr = idx_q[ukt_pkg::IDX_W-1:0];
          idx_d         = idx_nxt;
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
          unique case (kind_q)
            ukt_pkg::KIND_ADD: begin
              if (full) begin
                cmd_o.res_status = ukt_pkg::ST_FULL;
              end else if (sts_i.hit_k) begin
                cmd_o.res_status = ukt_pkg::ST_EXISTS;
              end else begin
                cmd_o.wr_en   = 1'b1;
                cmd_o.wr_addr = cnt_q[ukt_pkg::IDX_W-1:0];
                cmd_o.wr_sel  = ukt_pkg::WSEL_KEY;
                cnt_d         = cnt_q + ukt_pkg::CNT_W'(1);
              end
            end
            ukt_pkg::KIND_DEL: begin
              if (!sts_i.hit_k) begin
                cmd_o.res_status = ukt_pkg::ST_NOT_FOUND;
              end else begin
                idx_d     = ukt_pkg::CNT_W'(sts_i.at_idx);
                wr_pend_d = 1'b0;
                state_d   = ST_SHIFT;
              end
            end
            ukt_pkg::KIND_GET: begin
              if (!sts_i.hit_k) begin
                cmd_o.res_status = ukt_pkg::ST_NOT_FOUND;
              end else begin
                cmd_o.res_found = 1'b1;
              end
            end
            ukt_pkg::KIND_UPD: begin
              if (sts_i.hit_nk && (!sts_i.hit_k || (sts_i.other_idx != sts_i.at_idx))) begin
                cmd_o.res_status = ukt_pkg::ST_DUP;
              end else if (!sts_i.hit_k) begin
                cmd_o.res_status = ukt_pkg::ST_NOT_FOUND;
              end else begin
                cmd_o.wr_en   = 1'b1;
                cmd_o.wr_addr = sts_i.at_idx;
                cmd_o.wr_sel  = ukt_pkg::WSEL_NEW_KEY;
              end
            end
            default: begin
              cmd_o.res_status = ukt_pkg::ST_NOT_FOUND;
            end
          endcase
        end
      end
      ST_SHIFT: begin
        // read entry j+1, write it to slot j in the following cycle
        if (idx_nxt < cnt_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = idx_nxt[ukt_pkg::IDX_W-1:0];
          wr_pend_d     = 1'b1;
          wr_dst_d      = idx_q[ukt_pkg::IDX_W-1:0];
          idx_d         = idx_nxt;
        end else begin
          wr_pend_d = 1'b0;
        end
        if (wr_pend_q) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = wr_dst_q;
          cmd_o.wr_sel  = ukt_pkg::WSEL_SHIFT;
        end
        if (!(idx_nxt < cnt_q) && !wr_pend_q) begin
          cnt_d   = cnt_q - ukt_pkg::CNT_W'(1);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.res_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kind_q    <= ukt_pkg::KIND_ADD;
      cnt_q     <= '0;
      cap_q     <= ukt_pkg::CAP_RESET;
      idx_q     <= '0;
      wr_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      cnt_q     <= cnt_d;
      cap_q     <= cap_d;
      idx_q     <= idx_d;
      wr_pend_q <= wr_pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_dst_q <= wr_dst_d;
  end

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ukt_pkg::CNT_W'(ukt_pkg::DEPTH))
    else $error("entry count beyond table depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == $past(cnt_q) + ukt_pkg::CNT_W'(1)) ||
       (cnt_q == $past(cnt_q) - ukt_pkg::CNT_W'(1))))
    else $error("entry count moved by more than one");

  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_vld_q || out_ready_i))
    else $error("result loaded over a pending result");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SCAN))
    else $error("accepted request did not start a scan");

endmodule

/* sv/unique_key_table_engine_core.sv */
// channel   | direction | handshake                  | contents
// ----------+-----------+----------------------------+----------------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready | request: kind, key, new key, name
// m_axis    | out       | m_axis_tvalid/m_axis_tready | result: status, found key, found name
// cfg       | in        | cfg_we_i (no wait)         | capacity register
//
// one request at a time: accept, a scan of every stored entry, then decide;
//   a delete adds a shift that moves each entry behind the deleted one down a slot
// the scan rate is set by the single read port of the key/name table, one entry per cycle
// reset (rst_ni, async, active low) empties the table and sets capacity to 64
// a result sits in the output register; a stalled m_axis holds the next result in decide,
//   the following request is taken as soon as the block returns to idle
module unique_key_table_engine_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  // request channel
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [127:0]                 s_axis_tdata,  // key[31:0], new_key[63:32], entry_name[127:64]
  input  logic [ukt_pkg::KIND_W-1:0]   s_axis_tuser,  // kind[1:0]

  // result channel
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [103:0]                 m_axis_tdata,  // status[2:0], found_key[34:3],
                                                      // found_name[98:35], zero[103:99]

  // capacity register
  input  logic                         cfg_we_i,
  input  logic [ukt_pkg::CAP_W-1:0]    cfg_wdata_i
);

  ukt_pkg::cmd_t cmd;
  ukt_pkg::sts_t sts;

  logic [ukt_pkg::STATUS_W-1:0]  res_status;
  logic [ukt_pkg::KEY_W-1:0]     res_key;
  logic [ukt_pkg::NAME_IN_W-1:0] res_name;

  // sequencer: scan, decide, shift on delete, entry count and capacity
  ukt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // table memories, compare stage and result register
  ukt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_key_i     (s_axis_tdata[31:0]),
    .in_new_key_i (s_axis_tdata[63:32]),
    .in_name_i    (s_axis_tdata[127:64]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_status_o (res_status),
    .out_key_o    (res_key),
    .out_name_o   (res_name)
  );

  // pack the result, padded to whole bytes
  assign m_axis_tdata = {5'b0, res_name, res_key, res_status};

endmodule
